[rtl/packed_sample_expander_assert.svh]
// Assertion macros used by the packed sample expander RTL.
`ifndef PACKED_SAMPLE_EXPANDER_ASSERT_SVH
`define PACKED_SAMPLE_EXPANDER_ASSERT_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define PSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clk outside reset.
`define PSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pse_pkg.sv]
// Types, constants and helper functions of the packed sample expander.
package pse_pkg;

  localparam logic [3:0] FW_ONE   = 4'd1;
  localparam logic [3:0] FW_TWO   = 4'd2;
  localparam logic [3:0] FW_FOUR  = 4'd4;
  localparam logic [3:0] FW_EIGHT = 4'd8;

  typedef enum logic [1:0] {
    HDR_IDLE,
    HDR_MASK,
    HDR_CONST,
    HDR_DATA
  } hdr_pos_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXPAND
  } unpack_state_t;

  typedef struct packed {
    logic [3:0] width;
    logic [7:0] mask;
    logic [7:0] const_bits;
    logic       valid;
  } hdr_t;

  function automatic logic is_valid_width(input logic [7:0] b);
    return (b == {4'd0, FW_ONE}) || (b == {4'd0, FW_TWO}) ||
           (b == {4'd0, FW_FOUR}) || (b == {4'd0, FW_EIGHT});
  endfunction

  // Mask that keeps one packed value of the given width.
  function automatic logic [7:0] value_mask(input logic [3:0] w);
    logic [7:0] m;
    case (w)
      FW_ONE:  m = 8'h01;
      FW_TWO:  m = 8'h03;
      FW_FOUR: m = 8'h0F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  // Number of values in one data byte, minus one.
  function automatic logic [2:0] count_init(input logic [3:0] w);
    logic [2:0] c;
    case (w)
      FW_ONE:  c = 3'd7;
      FW_TWO:  c = 3'd3;
      FW_FOUR: c = 3'd1;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

[rtl/pse_if.sv]
// Valid/ready channel interfaces for payload bytes and rebuilt samples.
interface pse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       packet_start;

  modport source(output valid, output payload_byte, output packet_start, input ready);
  modport sink(input valid, input payload_byte, input packet_start, output ready);
endinterface

interface pse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;
  logic       last_of_byte;

  modport source(output valid, output sample, output last_of_byte, input ready);
  modport sink(input valid, input sample, input last_of_byte, output ready);
endinterface

[rtl/pse_deposit.sv]
// Bit deposit of one packed value into the channel mask, ORed with constant bits.
module pse_deposit (
  input  logic [7:0] value,
  input  logic [7:0] mask,
  input  logic [7:0] const_bits,
  output logic [7:0] sample
);

  logic [7:0] dep;
  logic [3:0] src;

  // Each set mask bit, lowest first, takes the next value bit.
  always_comb begin
    dep = 8'd0;
    src = 4'd0;
    for (int b = 0; b < 8; b++) begin
      if (mask[b]) begin
        dep[b] = value[src[2:0]];
        src    = src + 4'd1;
      end
    end
  end

  assign sample = dep | const_bits;

endmodule

[rtl/pse_hdr.sv]
// Packet header tracker: width, channel mask, constant bits and data gating.
module pse_hdr (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    payload_byte,
  input  logic          packet_start,
  output pse_pkg::hdr_t hdr,
  output logic          data_go
);
  import pse_pkg::*;

  hdr_pos_t   pos;
  logic [3:0] width;
  logic [7:0] mask;
  logic [7:0] const_bits;
  logic       valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= HDR_IDLE;
      width      <= 4'd0;
      mask       <= 8'd0;
      const_bits <= 8'd0;
      valid      <= 1'b0;
    end else if (accept) begin
      if (packet_start) begin
        width <= is_valid_width(payload_byte) ? payload_byte[3:0] : 4'd0;
        valid <= 1'b0;
        pos   <= HDR_MASK;
      end else begin
        unique case (pos)
          HDR_IDLE: begin
          end
          HDR_MASK: begin
            mask <= payload_byte;
            pos  <= HDR_CONST;
          end
          HDR_CONST: begin
            const_bits <= payload_byte;
            valid      <= (width != 4'd0);
            pos        <= HDR_DATA;
          end
          HDR_DATA: begin
          end
        endcase
      end
    end
  end

  assign hdr.width      = width;
  assign hdr.mask       = mask;
  assign hdr.const_bits = const_bits;
  assign hdr.valid      = valid;

  assign data_go = accept && !packet_start && (pos == HDR_DATA) && valid;

endmodule

[rtl/pse_unpack.sv]
// Sequencer that walks one data byte through the shared deposit unit.
`include "packed_sample_expander_assert.svh"

module pse_unpack (
  input  logic          clk,
  input  logic          rst,
  input  pse_pkg::hdr_t hdr,
  input  logic          data_go,
  input  logic [7:0]    payload_byte,
  output logic          idle,
  pse_out_if.source     samples
);
  import pse_pkg::*;

  unpack_state_t state, state_next;
  logic [7:0]    shreg;
  logic [2:0]    cnt;
  logic          out_valid;
  logic [7:0]    out_sample;
  logic          out_last;
  logic          step;
  logic [7:0]    dep_sample;

  pse_deposit u_deposit (
    .value      (shreg & value_mask(hdr.width)),
    .mask       (hdr.mask),
    .const_bits (hdr.const_bits),
    .sample     (dep_sample)
  );

  // One value moves into the output register whenever that register is free.
  assign step = (state == ST_EXPAND) && (!out_valid || samples.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (data_go) begin
          state_next = ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (step && (cnt == 3'd0)) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (data_go) begin
      shreg <= payload_byte;
      cnt   <= count_init(hdr.width);
    end else if (step) begin
      shreg <= shreg >> hdr.width;
      cnt   <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (samples.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_sample <= dep_sample;
      out_last   <= (cnt == 3'd0);
    end
  end

  assign idle                 = (state == ST_IDLE);
  assign samples.valid        = out_valid;
  assign samples.sample       = out_sample;
  assign samples.last_of_byte = out_last;

  `PSE_ASSERT_NEXT(a_go_expands, data_go && (state == ST_IDLE), state == ST_EXPAND, "data byte did not start expansion")
  `PSE_ASSERT_NEXT(a_last_ends, step && (cnt == 3'd0), (state == ST_IDLE) && out_valid && out_last, "final value did not end the byte")
  `PSE_ASSERT_NOW(a_cnt_bound, state == ST_EXPAND, cnt <= count_init(hdr.width), "value count beyond byte capacity")

endmodule

[rtl/packed_sample_expander.sv]
// Top level of the packed sample expander: header tracking and byte unpacking.
//
//   channel   role    payload                        beat
//   payload   sink    payload_byte[7:0], packet_start  one packet byte
//   samples   source  sample[7:0], last_of_byte        one rebuilt sample
//
// A data byte of a valid packet is taken and then yields 8/width samples,
// one per cycle while the output register drains; the one shared deposit
// unit sets that rate. No new byte is taken until the last sample of the
// byte has entered the sample register.
// Header bytes and ignored bytes start no unpacking, so payload stays ready.
// payload.ready is low while a byte is being unpacked; a stall on samples holds
// the sample register and pauses the unpacking.
// rst is synchronous and active high; it clears the header and the sequencer.
module packed_sample_expander (
  input  logic       clk,
  input  logic       rst,
  pse_in_if.sink     payload,
  pse_out_if.source  samples
);
  import pse_pkg::*;

  hdr_t hdr;
  logic accept;
  logic data_go;
  logic idle;

  // A beat is taken only while no byte is being unpacked.
  assign payload.ready = idle;
  assign accept        = payload.valid && idle;

  pse_hdr u_hdr (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .payload_byte (payload.payload_byte),
    .packet_start (payload.packet_start),
    .hdr          (hdr),
    .data_go      (data_go)
  );

  // The header registers change only on an accepted beat, which cannot occur
  // while unpacking, so the unpacker sees a stable mask and width.
  pse_unpack u_unpack (
    .clk          (clk),
    .rst          (rst),
    .hdr          (hdr),
    .data_go      (data_go),
    .payload_byte (payload.payload_byte),
    .idle         (idle),
    .samples      (samples)
  );

endmodule
